@@ rtl/fnr_pkg.sv @@
// Shared types and character constants for the formatted number recognizer.
package fnr_pkg;

   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_NBSP    = 8'hA0;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   typedef struct packed {
      logic [7:0] in_char;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_char_valid;
      logic       done_res;
      logic       accepted;
   } rsp_type;

endpackage

@@ rtl/fnr_core.sv @@
// Grammar state machine: holds parse state and computes the result of one byte.
module fnr_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  fnr_pkg::req_type req,
   output fnr_pkg::rsp_type rsp
);
   import fnr_pkg::*;

   typedef enum logic [3:0] {
      PH_LEAD    = 4'd0,
      PH_DOLLAR  = 4'd1,
      PH_SIGN    = 4'd2,
      PH_INT     = 4'd3,
      PH_GROUP   = 4'd4,
      PH_FRAC0   = 4'd5,
      PH_FRAC    = 4'd6,
      PH_TRAIL   = 4'd7,
      PH_PERCENT = 4'd8,
      PH_ERR     = 4'd9
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] count_ff, count_in;
   logic       dollar_ff, dollar_in;
   logic       trim_ff, trim_in;
   logic       emit;
   logic       final_ok;

   logic [7:0] c;
   logic       inner_ws, trim_ws, digit;

   assign c        = req.in_char;
   assign inner_ws = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   assign trim_ws  = inner_ws || (c == CHAR_NBSP);
   assign digit    = (c >= CHAR_ZERO) && (c <= CHAR_NINE);

   always_comb begin
      phase_in  = PH_ERR;
      count_in  = count_ff;
      dollar_in = dollar_ff;
      trim_in   = trim_ff;
      emit      = 1'b0;
      case (phase_ff)
         PH_LEAD, PH_DOLLAR: begin
            if ((phase_ff == PH_LEAD) ? trim_ws : inner_ws) begin
               phase_in = phase_ff;
            end else if (phase_ff == PH_LEAD && c == CHAR_DOLLAR) begin
               dollar_in = 1'b1;
               phase_in  = PH_DOLLAR;
            end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               phase_in = PH_SIGN;
               emit     = 1'b1;
            end else if (digit) begin
               phase_in = PH_INT;
               count_in = 3'd1;
               emit     = 1'b1;
            end
         end
         PH_SIGN: begin
            if (inner_ws) begin
               phase_in = PH_SIGN;
               emit     = 1'b1;
            end else if (digit) begin
               phase_in = PH_INT;
               count_in = 3'd1;
               emit     = 1'b1;
            end
         end
         PH_INT, PH_GROUP, PH_FRAC: begin
            if (digit) begin
               if (phase_ff == PH_GROUP) begin
                  // a group holds exactly three digits
                  if (count_ff < 3'd3) begin
                     count_in = count_ff + 3'd1;
                     phase_in = PH_GROUP;
                     emit     = 1'b1;
                  end
               end else begin
                  // run length saturates at four
                  if (count_ff < 3'd4) count_in = count_ff + 3'd1;
                  phase_in = phase_ff;
                  emit     = 1'b1;
               end
            end else if (phase_ff == PH_GROUP && count_ff != 3'd3) begin
               phase_in = PH_ERR;
            end else if (c == CHAR_COMMA) begin
               if (phase_ff != PH_FRAC && count_ff <= 3'd3) begin
                  phase_in = PH_GROUP;
                  count_in = 3'd0;
               end
            end else if (c == CHAR_DOT) begin
               if (phase_ff != PH_FRAC) begin
                  phase_in = PH_FRAC0;
                  emit     = 1'b1;
               end
            end else if (trim_ws) begin
               phase_in = PH_TRAIL;
               trim_in  = (c == CHAR_NBSP);
            end else if (c == CHAR_PERCENT) begin
               if (!dollar_ff) phase_in = PH_PERCENT;
            end
         end
         PH_FRAC0: begin
            if (digit) begin
               phase_in = PH_FRAC;
               emit     = 1'b1;
            end
         end
         PH_TRAIL: begin
            if (trim_ws) begin
               phase_in = PH_TRAIL;
               if (c == CHAR_NBSP) trim_in = 1'b1;
            end else if (c == CHAR_PERCENT && !dollar_ff && !trim_ff) begin
               phase_in = PH_PERCENT;
            end
         end
         PH_PERCENT: begin
            if (trim_ws) phase_in = PH_PERCENT;
         end
         default: begin
            phase_in = PH_ERR;
         end
      endcase
   end

   always_comb begin
      case (phase_in)
         PH_INT, PH_FRAC, PH_TRAIL, PH_PERCENT: final_ok = 1'b1;
         PH_GROUP:                              final_ok = (count_in == 3'd3);
         default:                               final_ok = 1'b0;
      endcase
   end

   assign rsp.out_char       = emit ? c : 8'd0;
   assign rsp.out_char_valid = emit;
   assign rsp.done_res       = req.last_char;
   assign rsp.accepted       = req.last_char && final_ok;

   // the last byte of a string sends the machine back to its start state
   always_ff @(posedge clock) begin
      if (reset || (step && req.last_char)) begin
         phase_ff  <= PH_LEAD;
         count_ff  <= 3'd0;
         dollar_ff <= 1'b0;
         trim_ff   <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         dollar_ff <= dollar_in;
         trim_ff   <= trim_in;
      end
   end

endmodule

@@ rtl/formatted_number_recognizer_unit.sv @@
// Top level of the formatted number recognizer: stream ports and pipeline registers.
//
// Usage:
//   Bytes of a text string arrive on the req_ channel, one per transaction,
//   with req_tlast marking the final byte. Every request transaction yields
//   exactly one response transaction on the rsp_ channel. rsp_tdata carries
//   the byte when it belongs to the extracted number (commas are dropped),
//   rsp_tuser[0] flags that, rsp_tlast marks the response to the final byte
//   and rsp_tuser[1] gives the verdict with it.
//   A byte is taken into the input register; its response is then registered
//   in the response register. Throughput: one byte per cycle while rsp_tready
//   stays high; the parse step is a single state transition between the input register and the response register.
//   Reset (synchronous, active high) empties both registers and puts the
//   parser in its leading whitespace state. After each final byte the parser
//   returns to that state on its own.
//   When the receiver stalls, the response register holds its transaction,
//   the input register keeps one more byte, and req_tready then drops.
module formatted_number_recognizer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,   // last_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [1:0] rsp_tuser,   // [0] out_char_valid, [1] accepted
   output logic       rsp_tlast    // done_res
);
   import fnr_pkg::*;

   // input register
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff;
   // response register
   logic    s2_valid_ff, s2_valid_in;
   rsp_type s2_rsp_ff;
   rsp_type step_rsp;
   req_type req_now;

   logic s2_ready;
   logic s1_move;
   logic req_take;

   assign req_now.in_char   = req_tdata;
   assign req_now.last_char = req_tlast;

   assign s2_ready   = !s2_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && s2_ready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in = req_take || (s1_valid_ff && !s2_ready);
   assign s2_valid_in = s1_move || (s2_valid_ff && !rsp_tready);

   // parser state advances only when its byte moves into the response register
   fnr_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (s1_move),
      .req   (s1_req_ff),
      .rsp   (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) s1_req_ff <= req_now;
      if (s1_move)  s2_rsp_ff <= step_rsp;
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = s2_rsp_ff.out_char;
   assign rsp_tuser  = {s2_rsp_ff.accepted, s2_rsp_ff.out_char_valid};
   assign rsp_tlast  = s2_rsp_ff.done_res;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for formatted_number_recognizer_unit: random and directed strings.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fnr_pkg::*;

   // Stimulus size and watchdog.
   localparam int TOTAL_BYTES = 1150;  // request bytes, directed part included
   localparam int QUIET_LIMIT = 2000;  // cycles with no transaction on either side
   localparam int DRAIN_CYCLES = 8;    // pipeline is two deep; a few spare cycles

   typedef logic [7:0] text_type[$];

   // Parser position inside the number grammar.
   typedef enum logic [3:0] {
      ST_LEADING,       // surrounding whitespace before the number
      ST_AFTER_DOLLAR,  // '$' taken, inner whitespace allowed
      ST_AFTER_SIGN,    // sign taken, inner whitespace passed out
      ST_WHOLE,         // plain integer digits
      ST_GROUPED,       // inside a ",ddd" group
      ST_POINT,         // '.' taken, a digit must follow
      ST_FRACTION,      // fraction digits
      ST_TRAILING,      // whitespace after the number
      ST_PERCENT,       // '%' taken, whitespace only
      ST_REJECT         // grammar broken, eat the rest of the string
   } parse_state_type;

   // Scoreboard: runs the grammar on every accepted byte and queues the
   // response it should produce; each response is checked against the oldest.
   class number_scoreboard;
      rsp_type         echo_expect_q[$];
      parse_state_type state;
      logic [2:0]      grp_digits;
      bit              saw_dollar;
      bit              saw_nbsp_tail;
      int              mismatches;
      int              bytes_in;
      int              strings_in;
      int              strings_matched;
      int              responses_checked;

      function new();
         restart();
      endfunction

      function void restart();
         state = ST_LEADING;
         grp_digits = 3'd0;
         saw_dollar = 1'b0;
         saw_nbsp_tail = 1'b0;
      endfunction

      function bit inner_ws(logic [7:0] c);
         return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
      endfunction

      function bit trim_ws(logic [7:0] c);
         return inner_ws(c) || c == CHAR_NBSP;
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CHAR_ZERO && c <= CHAR_NINE;
      endfunction

      // One grammar step; returns 1 when the byte belongs to the number.
      function bit parse_byte(logic [7:0] c);
         parse_state_type nxt;
         bit emit;
         nxt = ST_REJECT;
         emit = 1'b0;
         case (state)
            ST_LEADING, ST_AFTER_DOLLAR: begin
               if ((state == ST_LEADING) ? trim_ws(c) : inner_ws(c)) begin
                  nxt = state;
               end else if (state == ST_LEADING && c == CHAR_DOLLAR) begin
                  saw_dollar = 1'b1;
                  nxt = ST_AFTER_DOLLAR;
               end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                  nxt = ST_AFTER_SIGN;
                  emit = 1'b1;
               end else if (is_digit(c)) begin
                  nxt = ST_WHOLE;
                  grp_digits = 3'd1;
                  emit = 1'b1;
               end
            end
            ST_AFTER_SIGN: begin
               if (inner_ws(c)) begin
                  nxt = ST_AFTER_SIGN;
                  emit = 1'b1;
               end else if (is_digit(c)) begin
                  nxt = ST_WHOLE;
                  grp_digits = 3'd1;
                  emit = 1'b1;
               end
            end
            ST_WHOLE, ST_GROUPED, ST_FRACTION: begin
               if (is_digit(c)) begin
                  if (state == ST_GROUPED) begin
                     // a fourth digit in a group breaks the grammar
                     if (grp_digits < 3'd3) begin
                        grp_digits = grp_digits + 3'd1;
                        nxt = ST_GROUPED;
                        emit = 1'b1;
                     end
                  end else begin
                     if (grp_digits < 3'd4) grp_digits = grp_digits + 3'd1;
                     nxt = state;
                     emit = 1'b1;
                  end
               end else if (!(state == ST_GROUPED && grp_digits != 3'd3)) begin
                  if (c == CHAR_COMMA) begin
                     // comma after more than three plain digits is rejected
                     if (state != ST_FRACTION && grp_digits <= 3'd3) begin
                        nxt = ST_GROUPED;
                        grp_digits = 3'd0;
                     end
                  end else if (c == CHAR_DOT) begin
                     if (state != ST_FRACTION) begin
                        nxt = ST_POINT;
                        emit = 1'b1;
                     end
                  end else if (trim_ws(c)) begin
                     nxt = ST_TRAILING;
                     saw_nbsp_tail = (c == CHAR_NBSP);
                  end else if (c == CHAR_PERCENT) begin
                     if (!saw_dollar) nxt = ST_PERCENT;
                  end
               end
            end
            ST_POINT: begin
               if (is_digit(c)) begin
                  nxt = ST_FRACTION;
                  emit = 1'b1;
               end
            end
            ST_TRAILING: begin
               if (trim_ws(c)) begin
                  nxt = ST_TRAILING;
                  if (c == CHAR_NBSP) saw_nbsp_tail = 1'b1;
               end else if (c == CHAR_PERCENT && !saw_dollar && !saw_nbsp_tail) begin
                  nxt = ST_PERCENT;
               end
            end
            ST_PERCENT: begin
               if (trim_ws(c)) nxt = ST_PERCENT;
            end
            default: nxt = ST_REJECT;
         endcase
         state = nxt;
         return emit;
      endfunction

      function bit verdict_ok();
         case (state)
            ST_WHOLE, ST_FRACTION, ST_TRAILING, ST_PERCENT: return 1'b1;
            ST_GROUPED: return grp_digits == 3'd3;
            default: return 1'b0;
         endcase
      endfunction

      function void note_input(logic [7:0] c, logic last_byte);
         rsp_type e;
         bit emit;
         emit = parse_byte(c);
         e.out_char = emit ? c : 8'h00;
         e.out_char_valid = emit;
         e.done_res = last_byte;
         e.accepted = last_byte && verdict_ok();
         echo_expect_q = {echo_expect_q, e};
         bytes_in++;
         if (last_byte) begin
            strings_in++;
            if (e.accepted) strings_matched++;
            restart();
         end
      endfunction

      task report(string what);
         $display("%0t ns mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      task check_result(logic [7:0] data, logic [1:0] user, logic last_rsp);
         rsp_type e;
         if (echo_expect_q.size() == 0) begin
            report($sformatf("response %h/%b/%b with nothing outstanding",
                             data, user, last_rsp));
         end else begin
            e = echo_expect_q.pop_front();
            responses_checked++;
            if (data !== e.out_char)
               report($sformatf("out_char %h, expected %h", data, e.out_char));
            if (user[0] !== e.out_char_valid)
               report($sformatf("out_char_valid %b, expected %b", user[0],
                                e.out_char_valid));
            if (last_rsp !== e.done_res)
               report($sformatf("done %b, expected %b", last_rsp, e.done_res));
            if (user[1] !== e.accepted)
               report($sformatf("accepted %b, expected %b", user[1], e.accepted));
         end
      endtask
   endclass

   // Block ports; every input starts at a known value.
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;  // [7:0] in_char
   logic       req_tlast = 1'b0;   // last_char
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [7:0] out_char
   logic [1:0] rsp_tuser;          // [0] out_char_valid, [1] accepted
   logic       rsp_tlast;          // done_res

   number_scoreboard sb = new();

   int send_gap_pct = 17;    // chance of a sender gap before each byte
   int recv_stall_pct = 73;  // chance of rsp_tready low in a cycle
   int bytes_sent = 0;
   int quiet_cycles = 0;

   formatted_number_recognizer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // Receiver back-pressure: a fresh draw every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Monitors. Both sample at the rising edge, before any NBA of this edge
   // lands, so they see the handshake exactly as the block saw it.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_input(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Cycles since the last transaction on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Watchdog: a hung handshake ends the run.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("timeout: no transaction for %0d cycles, %0d responses outstanding",
               QUIET_LIMIT, sb.echo_expect_q.size());
      $display("formatted_number_recognizer_unit verification failed");
      $finish;
   end

   // One byte per request transaction. Gaps drop tvalid for whole cycles;
   // tvalid then stays high until the transaction is taken.
   task send_byte(input logic [7:0] c, input logic last_byte);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= last_byte;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task send_string(input text_type s);
      for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1);
      bytes_sent += s.size();
   endtask

   function automatic text_type to_text(string t);
      text_type s;
      for (int i = 0; i < t.len(); i++) s = {s, 8'(t[i])};
      return s;
   endfunction

   function automatic logic [7:0] digit_char();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // space or TAB..CR
   function automatic logic [7:0] inner_ws_char();
      int k;
      k = $urandom_range(0, 5);
      return (k == 0) ? CHAR_SPACE : CHAR_TAB + 8'(k - 1);
   endfunction

   // inner whitespace or the no-break space
   function automatic logic [7:0] trim_ws_char();
      return ($urandom_range(0, 6) == 0) ? CHAR_NBSP : inner_ws_char();
   endfunction

   // Mostly well-formed numbers with random content; some get one byte
   // overwritten, mostly with a grammar-relevant character, a few are pure noise.
   function automatic text_type random_string();
      text_type s;
      int kind;
      bit with_dollar;
      bit with_percent;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(1, 8)) s = {s, 8'($urandom_range(0, 255))};
      end else begin
         with_dollar = ($urandom_range(0, 3) == 0);
         with_percent = !with_dollar && ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(0, 2)) s = {s, trim_ws_char()};
         if (with_dollar) begin
            s = {s, CHAR_DOLLAR};
            repeat ($urandom_range(0, 1)) s = {s, inner_ws_char()};
         end
         if ($urandom_range(0, 1)) begin
            s = {s, ($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS)};
            repeat ($urandom_range(0, 1)) s = {s, inner_ws_char()};
         end
         if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 6)) s = {s, digit_char()};
         end else begin
            repeat ($urandom_range(1, 3)) s = {s, digit_char()};
            repeat ($urandom_range(1, 3)) begin
               s = {s, CHAR_COMMA};
               repeat (3) s = {s, digit_char()};
            end
         end
         if ($urandom_range(0, 2) == 0) begin
            s = {s, CHAR_DOT};
            repeat ($urandom_range(1, 3)) s = {s, digit_char()};
         end
         repeat ($urandom_range(0, 2)) s = {s, trim_ws_char()};
         if (with_percent) begin
            s = {s, CHAR_PERCENT};
            repeat ($urandom_range(0, 1)) s = {s, trim_ws_char()};
         end
         if (kind <= 2) begin
            case ($urandom_range(0, 8))
               0: s[$urandom_range(0, s.size() - 1)] = CHAR_COMMA;
               1: s[$urandom_range(0, s.size() - 1)] = CHAR_DOT;
               2: s[$urandom_range(0, s.size() - 1)] = CHAR_DOLLAR;
               3: s[$urandom_range(0, s.size() - 1)] = CHAR_PERCENT;
               4: s[$urandom_range(0, s.size() - 1)] = CHAR_PLUS;
               5: s[$urandom_range(0, s.size() - 1)] = CHAR_MINUS;
               6: s[$urandom_range(0, s.size() - 1)] = digit_char();
               7: s[$urandom_range(0, s.size() - 1)] = CHAR_NBSP;
               default: s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
            endcase
         end
      end
      return s;
   endfunction

   initial begin
      text_type s;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed strings: grouping with '$' and fraction, sign followed by
      // whitespace with '%', a short last group, no-break space ahead of '%',
      // no-break space after a sign, whitespace only, byte extremes, and
      // '$' together with '%'.
      send_string(to_text("$1,234.5"));
      send_string(to_text("-\t7%"));
      send_string(to_text("1,23"));
      s = '{CHAR_NINE, CHAR_NBSP, CHAR_PERCENT};
      send_string(s);
      s = '{CHAR_PLUS, CHAR_NBSP};
      send_string(s);
      s = '{CHAR_NBSP, CHAR_SPACE};
      send_string(s);
      s = '{8'h00, 8'hFF};
      send_string(s);
      send_string(to_text("$5%"));

      // Random strings in three idling modes: slow receiver, slow sender,
      // then full rate on both sides.
      for (int round = 0; round < 3; round++) begin
         case (round)
            0: begin
               send_gap_pct = 17;
               recv_stall_pct = 73;
            end
            1: begin
               send_gap_pct = 73;
               recv_stall_pct = 17;
            end
            default: begin
               send_gap_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         while (bytes_sent < (round + 1) * TOTAL_BYTES / 3) send_string(random_string());
      end
      req_tvalid <= 1'b0;

      // Drain; the watchdog covers a response that never shows up.
      while (sb.echo_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d bytes in %0d strings, %0d strings matched the grammar",
               sb.bytes_in, sb.strings_in, sb.strings_matched);
      $display("%0d responses checked, %0d mismatches", sb.responses_checked,
               sb.mismatches);
      if (sb.mismatches == 0)
         $display("formatted_number_recognizer_unit verification clean");
      else
         $display("formatted_number_recognizer_unit verification failed");
      $finish;
   end

endmodule
